// ----- hw/rtl/mocp_pkg.sv -----
// ----------------------------------------------------------------------------
// mocp_pkg
// Shared types and constants for the motor overcurrent trip and retry block.
// ----------------------------------------------------------------------------
`default_nettype none

package mocp_pkg;

  // default current sample width
  localparam int MOCP_CURRENT_BITS = 16;

  // configuration port geometry
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // field widths
  localparam int THR_BITS     = 15;
  localparam int TICK_BITS    = 8;
  localparam int DELAY_BITS   = 16;
  localparam int MAXR_BITS    = 4;
  localparam int RESTART_BITS = 5;

  // largest restart count the block can reach (max_restarts + 1)
  localparam logic [RESTART_BITS-1:0] RESTART_CEIL = RESTART_BITS'(16);

  // register reset values
  localparam logic [THR_BITS-1:0]   THR_RST   = THR_BITS'(1000);
  localparam logic [TICK_BITS-1:0]  TRIP_RST  = TICK_BITS'(14);
  localparam logic [TICK_BITS-1:0]  RECOV_RST = TICK_BITS'(100);
  localparam logic [DELAY_BITS-1:0] DELAY_RST = DELAY_BITS'(1200);
  localparam logic [MAXR_BITS-1:0]  MAXR_RST  = MAXR_BITS'(8);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_TRIP_TICKS    = 3'd1,
    CFG_RECOVER_TICKS = 3'd2,
    CFG_RESTART_DELAY = 3'd3,
    CFG_MAX_RESTARTS  = 3'd4
  } cfg_index_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [THR_BITS-1:0]   overcurrent_threshold;
    logic [TICK_BITS-1:0]  trip_ticks;
    logic [TICK_BITS-1:0]  recover_ticks;
    logic [DELAY_BITS-1:0] restart_delay_ticks;
    logic [MAXR_BITS-1:0]  max_restarts;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mocp_if.sv -----
// ----------------------------------------------------------------------------
// mocp_in_if / mocp_out_if
// Valid/ready channels carrying protection ticks and protection results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mocp_in_if
  import mocp_pkg::*;
#(
  parameter int CURRENT_BITS = MOCP_CURRENT_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           motor_running;
  logic signed [CURRENT_BITS-1:0] motor_current;

  modport source (output valid, output motor_running, output motor_current, input ready);
  modport sink   (input valid, input motor_running, input motor_current, output ready);
endinterface

interface mocp_out_if
  import mocp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    overcurrent_fault;
  logic [RESTART_BITS-1:0] restarts_used;
  logic                    locked_out;

  modport source (output valid, output overcurrent_fault, output restarts_used,
                  output locked_out, input ready);
  modport sink   (input valid, input overcurrent_fault, input restarts_used,
                  input locked_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mocp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mocp_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mocp_cfg_regs
  import mocp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output cfg_t                           cfg
);

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overcurrent_threshold <= THR_RST;
      cfg.trip_ticks            <= TRIP_RST;
      cfg.recover_ticks         <= RECOV_RST;
      cfg.restart_delay_ticks   <= DELAY_RST;
      cfg.max_restarts          <= MAXR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:     cfg.overcurrent_threshold <= cfg_wdata[THR_BITS-1:0];
        CFG_TRIP_TICKS:    cfg.trip_ticks            <= cfg_wdata[TICK_BITS-1:0];
        CFG_RECOVER_TICKS: cfg.recover_ticks         <= cfg_wdata[TICK_BITS-1:0];
        CFG_RESTART_DELAY: cfg.restart_delay_ticks   <= cfg_wdata[DELAY_BITS-1:0];
        CFG_MAX_RESTARTS:  cfg.max_restarts          <= cfg_wdata[MAXR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mocp_core.sv -----
// ----------------------------------------------------------------------------
// mocp_core
// Input register, tick evaluation against protection state, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mocp_core
  import mocp_pkg::*;
#(
  parameter int CURRENT_BITS = MOCP_CURRENT_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  cfg_t        cfg,
  mocp_in_if.sink     in_ch,
  mocp_out_if.source  out_ch
);

  // compare width covers 10*|current| and 9*threshold
  localparam int BASE_BITS = (CURRENT_BITS > THR_BITS) ? CURRENT_BITS : THR_BITS;
  localparam int CMP_BITS  = BASE_BITS + 4;

  // input register
  logic                           s1_valid;
  logic                           s1_running;
  logic signed [CURRENT_BITS-1:0] s1_current;

  // protection state
  logic                    fault_flag;
  logic [TICK_BITS-1:0]    trip_count;
  logic [TICK_BITS-1:0]    normal_count;
  logic [DELAY_BITS-1:0]   reclose_timer;
  logic [RESTART_BITS-1:0] restart_count;

  logic                    fault_flag_next;
  logic [TICK_BITS-1:0]    trip_count_next;
  logic [TICK_BITS-1:0]    normal_count_next;
  logic [DELAY_BITS-1:0]   reclose_timer_next;
  logic [RESTART_BITS-1:0] restart_count_next;

  logic                    advance;
  logic [CURRENT_BITS-1:0] mag;
  logic [CMP_BITS-1:0]     mag_w;
  logic [CMP_BITS-1:0]     thr_w;
  logic                    over;
  logic                    norm;
  logic [RESTART_BITS:0]   restart_inc;

  // pipeline flow: the input register drains into the result register
  assign advance     = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_running <= in_ch.motor_running;
      s1_current <= in_ch.motor_current;
    end
  end

  // magnitude and threshold tests
  assign mag   = s1_current[CURRENT_BITS-1] ? CURRENT_BITS'(-s1_current)
                                            : CURRENT_BITS'(s1_current);
  assign mag_w = CMP_BITS'(mag);
  assign thr_w = CMP_BITS'(cfg.overcurrent_threshold);
  assign over  = mag_w >= thr_w;
  assign norm  = ((mag_w << 3) + (mag_w << 1)) <= ((thr_w << 3) + thr_w);

  // tick evaluation: trip, then recovery, then restart
  always_comb begin
    fault_flag_next    = fault_flag;
    trip_count_next    = trip_count;
    normal_count_next  = normal_count;
    reclose_timer_next = reclose_timer;
    restart_count_next = restart_count;
    restart_inc        = {1'b0, restart_count} + 1'b1;

    if (s1_running) begin
      if (over) begin
        normal_count_next = '0;
        trip_count_next   = trip_count + 1'b1;
        if (trip_count_next > cfg.trip_ticks) begin
          trip_count_next = '0;
          fault_flag_next = 1'b1;
        end
      end
      if (norm) begin
        normal_count_next = normal_count_next + 1'b1;
        if (normal_count_next > cfg.recover_ticks) begin
          normal_count_next  = '0;
          trip_count_next    = '0;
          fault_flag_next    = 1'b0;
          restart_count_next = '0;
        end
      end
    end else begin
      normal_count_next = '0;
      trip_count_next   = '0;
    end

    restart_inc = {1'b0, restart_count_next} + 1'b1;
    if (fault_flag_next) begin
      reclose_timer_next = reclose_timer + 1'b1;
      if (reclose_timer_next > cfg.restart_delay_ticks) begin
        reclose_timer_next = '0;
        if (restart_inc < (RESTART_BITS + 1)'(cfg.max_restarts)) begin
          restart_count_next = restart_inc[RESTART_BITS-1:0];
          fault_flag_next    = 1'b0;
        end else begin
          restart_count_next = RESTART_BITS'(cfg.max_restarts) + 1'b1;
        end
      end
    end else begin
      reclose_timer_next = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_flag    <= 1'b0;
      trip_count    <= '0;
      normal_count  <= '0;
      reclose_timer <= '0;
      restart_count <= '0;
    end else if (advance) begin
      fault_flag    <= fault_flag_next;
      trip_count    <= trip_count_next;
      normal_count  <= normal_count_next;
      reclose_timer <= reclose_timer_next;
      restart_count <= restart_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.overcurrent_fault <= fault_flag_next;
      out_ch.restarts_used     <= restart_count_next;
      out_ch.locked_out        <= restart_count_next > RESTART_BITS'(cfg.max_restarts);
    end
  end

  // checks
  a_restart_bound: assert property (@(posedge clk) disable iff (rst)
    restart_count <= RESTART_CEIL)
    else $error("restart count above its ceiling");

  a_delay_idle: assert property (@(posedge clk) disable iff (rst)
    !fault_flag |-> reclose_timer == '0)
    else $error("delay counter running without a fault");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_ch.valid)
    else $error("result register not loaded after advance");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_ch.valid && !out_ch.ready))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ----- hw/rtl/motor_overcurrent_trip_retry.sv -----
// ----------------------------------------------------------------------------
// motor_overcurrent_trip_retry
// Overcurrent protection with automatic reclose, one protection tick per item.
//
// in_ch carries one tick (motor_running, signed motor_current) per transaction;
// out_ch returns one result (overcurrent_fault, restarts_used, locked_out) for
// every tick, in order. The cfg_we / cfg_index / cfg_wdata port writes the five
// limit registers; write only while no tick is in flight.
// A tick passes the input register, then the result register, before its
// result shows on out_ch. Throughput is one tick per cycle while out_ch is
// not stalled; the state update between the two registers is combinational.
// Reset clears the trip, normal, delay and restart counters and the fault flag
// and loads the default limits. When the receiver stalls, the result register
// holds and the input register still takes one more tick; in_ch.ready drops
// only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_overcurrent_trip_retry
  import mocp_pkg::*;
#(
  parameter int CURRENT_BITS = MOCP_CURRENT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  mocp_in_if.sink                        in_ch,
  mocp_out_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  cfg_t cfg;

  // limit registers
  mocp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick datapath
  mocp_core #(
    .CURRENT_BITS (CURRENT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
